@@ design/multi_motor_speed_sync_unit_defines.svh @@
// assertion macros used by the port-level checker file
`ifndef MULTI_MOTOR_SPEED_SYNC_UNIT_DEFINES_SVH
`define MULTI_MOTOR_SPEED_SYNC_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define MSSU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define MSSU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/mssu_pkg.sv @@
// shared types and constants of the motor speed sync unit
`default_nettype none

package mssu_pkg;

  localparam int unsigned MAX_MOTORS  = 4;
  localparam int unsigned MOTORS_DFLT = 4;
  localparam int unsigned SPEED_W     = 16;
  localparam int unsigned SMOOTH_W    = 15;
  localparam int unsigned CNT_W       = 17;
  localparam int unsigned COEF_W      = 16;
  localparam int unsigned THR_W       = 31;
  localparam int unsigned MASK_W      = 4;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam int unsigned IN_TDATA_W  = 96;
  localparam int unsigned OUT_FIELD_W = 34;
  localparam int unsigned OUT_TDATA_W = 40;

  localparam logic [COEF_W-1:0] GAIN_RST  = 16'd6554;
  localparam logic [COEF_W-1:0] FRAC_RST  = 16'd32768;
  localparam logic [COEF_W-1:0] TICKS_RST = 16'd10;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS = 2'd2;

  typedef enum logic [1:0] {
    KIND_OK,
    KIND_INVALID,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    logic              load;
    kind_t             load_kind;
    logic              move;
    kind_t             move_kind;
    logic [COEF_W-1:0] gain;
    logic [COEF_W-1:0] ticks;
    logic [THR_W-1:0]  thr;
  } lane_ctl_t;

  typedef struct packed {
    logic                status;
    logic [SMOOTH_W-1:0] sync;
    logic [SMOOTH_W-1:0] setpoint;
    logic [MASK_W-1:0]   mask;
  } merge_res_t;

endpackage

`default_nettype wire

@@ design/mssu_lane.sv @@
// one motor lane: ema smoothing, low-speed counter and fault flag
`default_nettype none

module mssu_lane
  import mssu_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lane_ctl_t           ctl,
  input  wire logic [SPEED_W-1:0]  speed_raw,
  output logic      [SMOOTH_W-1:0] sm_o,
  output logic                     flt_o
);

  logic [SMOOTH_W-1:0] sm_r, sm_nxt;
  logic [SMOOTH_W-1:0] s2_sm_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                flt_r, flt_nxt;

  logic [SMOOTH_W-1:0]   v;
  logic signed [16:0]    gain_s;
  logic signed [15:0]    diff;
  logic signed [32:0]    prod;
  logic signed [16:0]    sum;
  logic                  low;
  logic [CNT_W-1:0]      limit;

  // negative speeds count as standstill
  assign v = speed_raw[SPEED_W-1] ? '0 : speed_raw[SMOOTH_W-1:0];

  // old + floor(gain * (v - old) / 2^16)
  always_comb begin
    gain_s = $signed({1'b0, ctl.gain});
    diff   = $signed({1'b0, v}) - $signed({1'b0, sm_r});
    prod   = 33'(gain_s) * 33'(diff);
    sum    = $signed({2'b00, sm_r}) + prod[32:16];
  end

  always_comb begin
    sm_nxt = sm_r;
    if (ctl.load) begin
      case (ctl.load_kind)
        KIND_OK:    sm_nxt = sum[SMOOTH_W-1:0];
        KIND_CLEAR: sm_nxt = '0;
        default:    sm_nxt = sm_r;
      endcase
    end
  end

  // sm_r holds the value of the item sitting in the first stage
  assign low   = {sm_r, 16'b0} < ctl.thr;
  assign limit = {1'b0, ctl.ticks} + 17'd1;

  always_comb begin
    cnt_nxt = cnt_r;
    flt_nxt = flt_r;
    if (ctl.move) begin
      case (ctl.move_kind)
        KIND_OK: begin
          if (low) begin
            if (cnt_r < limit) begin
              cnt_nxt = cnt_r + 17'd1;
            end
          end else begin
            cnt_nxt = '0;
            flt_nxt = 1'b0;
          end
          if (cnt_nxt >= {1'b0, ctl.ticks}) begin
            flt_nxt = 1'b1;
          end
        end
        KIND_CLEAR: begin
          cnt_nxt = '0;
          flt_nxt = 1'b0;
        end
        default: begin
          cnt_nxt = cnt_r;
          flt_nxt = flt_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sm_r  <= '0;
      cnt_r <= '0;
      flt_r <= 1'b0;
    end else begin
      sm_r  <= sm_nxt;
      cnt_r <= cnt_nxt;
      flt_r <= flt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.move) begin
      s2_sm_r <= sm_r;
    end
  end

  assign sm_o  = s2_sm_r;
  assign flt_o = flt_r;

endmodule

`default_nettype wire

@@ design/mssu_merge.sv @@
// merge of the lanes: minimum over healthy motors and result fields
`default_nettype none

module mssu_merge
  import mssu_pkg::*;
#(
  parameter int unsigned MOTORS = MOTORS_DFLT
) (
  input  wire kind_t               kind,
  input  wire logic [SMOOTH_W-1:0] cmd,
  input  wire logic [SMOOTH_W-1:0] sm [MAX_MOTORS],
  input  wire logic [MASK_W-1:0]   flt,
  input  wire logic [SMOOTH_W-1:0] last_sync,
  output merge_res_t               res
);

  logic [SMOOTH_W-1:0] sync;
  logic                any;

  // falls back to the commanded speed when every motor is faulted
  always_comb begin
    sync = cmd;
    any  = 1'b0;
    for (int i = 0; i < MAX_MOTORS; i++) begin
      if (i < MOTORS && !flt[i] && (!any || sm[i] < sync)) begin
        sync = sm[i];
        any  = 1'b1;
      end
    end
  end

  always_comb begin
    case (kind)
      KIND_OK: begin
        res.status   = 1'b0;
        res.sync     = sync;
        res.setpoint = (cmd < sync) ? cmd : sync;
        res.mask     = flt;
      end
      KIND_INVALID: begin
        res.status   = 1'b1;
        res.sync     = last_sync;
        res.setpoint = '0;
        res.mask     = flt;
      end
      default: begin
        res.status   = 1'b0;
        res.sync     = '0;
        res.setpoint = '0;
        res.mask     = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/multi_motor_speed_sync_unit.sv @@
// top level of the multi-motor speed sync unit
//
// input beats (in_*): in_tuser is the request kind, 0 update, 1 clear of all
// stored state; in_tdata carries four signed q8.8 speeds, the commanded speed
// and the step time. a negative command or a zero step time gives an invalid
// result and leaves the state alone.
// result beats (out_*): out_tuser is the status bit, out_tdata holds sync speed,
// setpoint and fault mask. exactly one result beat per input beat, in order.
// config writes (cfg_*): index 0 smoothing gain, 1 fault fraction, 2 fault
// ticks, index 3 is dropped; cfg_ready is always high. write only while idle.
// pipeline: three stages, one beat per cycle while out_tready is high. stage one
// does the ema multiply per lane, stage two the fault counters, stage three the min
// merge into the output register, whose valid bit drives out_tvalid.
// each stage fills independently, so new beats are taken while a result waits;
// with out_tready low the three stages fill and in_tready drops until it returns.
// reset clears all motor state, the pipeline and the registers to their
// defaults; in_tready is high from the first cycle out of reset.
`default_nettype none

module multi_motor_speed_sync_unit
  import mssu_pkg::*;
#(
  parameter int unsigned MOTORS = MOTORS_DFLT
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // speed_0..speed_3, commanded_speed, step_time, 16 bits each
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // req_type
  input  wire logic                   in_tuser,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // sync_speed[14:0], setpoint[29:15], fault_mask[33:30], zero fill
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // status
  output logic                        out_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [COEF_W-1:0]      cfg_data
);

  // config registers
  logic [COEF_W-1:0] gain_r, frac_r, ticks_r;

  // stage valid bits and handshake
  logic v1_r, v2_r, v3_r;
  logic ready1, ready2, ready3;
  logic load1, move12, move23;

  // stage payload
  kind_t               s1_kind_r, s2_kind_r, in_kind;
  logic [SMOOTH_W-1:0] s1_cmd_r, s2_cmd_r;
  logic [THR_W-1:0]    s1_thr_r;
  logic [SPEED_W-1:0]  in_cmd, in_step;

  // output register and sync memory
  merge_res_t          res, out_r;
  logic [SMOOTH_W-1:0] last_sync_r;

  lane_ctl_t           ctl;
  logic [SMOOTH_W-1:0] lane_sm [MAX_MOTORS];
  logic [MASK_W-1:0]   lane_flt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= GAIN_RST;
      frac_r  <= FRAC_RST;
      ticks_r <= TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN:  gain_r  <= cfg_data;
        REG_FRAC:  frac_r  <= cfg_data;
        REG_TICKS: ticks_r <= cfg_data;
        default:   ;
      endcase
    end
  end

  // each stage takes a beat when empty or when its content moves on
  assign ready3    = !v3_r || out_tready;
  assign ready2    = !v2_r || ready3;
  assign ready1    = !v1_r || ready2;
  assign in_tready = ready1;
  assign load1     = in_tvalid && ready1;
  assign move12    = v1_r && ready2;
  assign move23    = v2_r && ready3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= load1 || (v1_r && !ready2);
      v2_r <= move12 || (v2_r && !ready3);
      v3_r <= move23 || (v3_r && !out_tready);
    end
  end

  // request classification at the input
  assign in_cmd  = in_tdata[4*SPEED_W +: SPEED_W];
  assign in_step = in_tdata[5*SPEED_W +: SPEED_W];

  always_comb begin
    if (in_tuser) begin
      in_kind = KIND_CLEAR;
    end else if (in_cmd[SPEED_W-1] || in_step == '0) begin
      in_kind = KIND_INVALID;
    end else begin
      in_kind = KIND_OK;
    end
  end

  // threshold product is registered before the lane compare
  always_ff @(posedge clk) begin
    if (load1) begin
      s1_kind_r <= in_kind;
      s1_cmd_r  <= in_cmd[SMOOTH_W-1:0];
      s1_thr_r  <= THR_W'(frac_r) * THR_W'(in_cmd[SMOOTH_W-1:0]);
    end
    if (move12) begin
      s2_kind_r <= s1_kind_r;
      s2_cmd_r  <= s1_cmd_r;
    end
  end

  always_comb begin
    ctl.load      = load1;
    ctl.load_kind = in_kind;
    ctl.move      = move12;
    ctl.move_kind = s1_kind_r;
    ctl.gain      = gain_r;
    ctl.ticks     = ticks_r;
    ctl.thr       = s1_thr_r;
  end

  // one lane per motor; missing motors read as faulted-free zeros
  for (genvar g = 0; g < MAX_MOTORS; g++) begin : g_lane
    if (g < MOTORS) begin : g_on
      mssu_lane u_lane (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .speed_raw (in_tdata[g*SPEED_W +: SPEED_W]),
        .sm_o      (lane_sm[g]),
        .flt_o     (lane_flt[g])
      );
    end else begin : g_off
      assign lane_sm[g]  = '0;
      assign lane_flt[g] = 1'b0;
    end
  end

  mssu_merge #(
    .MOTORS (MOTORS)
  ) u_merge (
    .kind      (s2_kind_r),
    .cmd       (s2_cmd_r),
    .sm        (lane_sm),
    .flt       (lane_flt),
    .last_sync (last_sync_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (move23) begin
      out_r <= res;
    end
  end

  // last sync is reported by invalid requests
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_sync_r <= '0;
    end else if (move23) begin
      case (s2_kind_r)
        KIND_OK:    last_sync_r <= res.sync;
        KIND_CLEAR: last_sync_r <= '0;
        default:    last_sync_r <= last_sync_r;
      endcase
    end
  end

  assign out_tvalid = v3_r;
  assign out_tuser  = out_r.status;
  assign out_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}},
                       out_r.mask, out_r.setpoint, out_r.sync};

endmodule

`default_nettype wire

@@ design/mssu_checker.sv @@
// port-level checks on the result channel of the speed sync unit
`default_nettype none
`include "multi_motor_speed_sync_unit_defines.svh"

module mssu_port_sva
  import mssu_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  `MSSU_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result beat changed while stalled")

  `MSSU_ASSERT_NOW(a_invalid_setp, out_tvalid && out_tuser, out_tdata[29:15] == 15'd0, "invalid result with nonzero setpoint")

  `MSSU_ASSERT_NOW(a_setp_le_sync, out_tvalid && !out_tuser, out_tdata[29:15] <= out_tdata[14:0], "setpoint above sync speed")

  `MSSU_ASSERT_NOW(a_all_faulted, out_tvalid && !out_tuser && out_tdata[33:30] == 4'hF, out_tdata[29:15] == out_tdata[14:0], "all faulted but setpoint differs from sync")

endmodule

bind multi_motor_speed_sync_unit mssu_port_sva u_mssu_checker (.*);

`default_nettype wire

@@ dv/mssu_tb_pkg.sv @@
// request, status and register codes shared by the speed sync testbench files
`timescale 1ns / 1ps

package mssu_tb_pkg;

  import mssu_pkg::*;

  localparam logic REQ_UPDATE = 1'b0;
  localparam logic REQ_CLEAR  = 1'b1;

  localparam logic STAT_OK      = 1'b0;
  localparam logic STAT_INVALID = 1'b1;

  // index past the last register, the block drops it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

endpackage

@@ dv/mssu_checker.sv @@
// checker of the speed sync unit: predicts every result beat and compares it
`timescale 1ns / 1ps

module mssu_checker
  import mssu_pkg::*;
  import mssu_tb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_data,
  output int                    fail_count,
  output int                    pending
);

  // per-motor filter and fault tracking
  logic [SMOOTH_W-1:0]   avg_speed [MAX_MOTORS];
  logic [CNT_W-1:0]      low_run   [MAX_MOTORS];
  logic [MAX_MOTORS-1:0] faulted;
  logic [SMOOTH_W-1:0]   held_sync;

  logic [COEF_W-1:0] gain, frac, ticks;

  merge_res_t results_due[$];
  merge_res_t want;
  int         mismatches = 0;

  function automatic void clear_motors();
    for (int i = 0; i < MAX_MOTORS; i++) begin
      avg_speed[i] = '0;
      low_run[i]   = '0;
    end
    faulted   = '0;
    held_sync = '0;
  endfunction

  // advances the motor state by one request and returns the result it gives
  function automatic merge_res_t next_sync_result(input logic kind,
                                                  input logic [IN_TDATA_W-1:0] beat);
    merge_res_t          r;
    logic [SPEED_W-1:0]  cmd_raw, v_raw;
    logic [63:0]         cmd, v, acc, thr, sync, lvl, cnt, lim;
    logic                any;
    r   = '0;
    any = 1'b0;
    if (kind == REQ_CLEAR) begin
      clear_motors();
      return r;
    end
    cmd_raw = beat[4*SPEED_W +: SPEED_W];
    if (cmd_raw[SPEED_W-1] || beat[5*SPEED_W +: SPEED_W] == '0) begin
      r.status = STAT_INVALID;
      r.sync   = held_sync;
      r.mask   = faulted;
      return r;
    end
    cmd = cmd_raw;
    thr = frac * cmd;
    lim = ticks;
    for (int i = 0; i < MAX_MOTORS; i++) begin
      v_raw = beat[i*SPEED_W +: SPEED_W];
      v     = v_raw[SPEED_W-1] ? 64'd0 : {48'd0, v_raw};
      acc   = gain * v + (64'd65536 - gain) * avg_speed[i];
      avg_speed[i] = acc[16 +: SMOOTH_W];
    end
    for (int i = 0; i < MAX_MOTORS; i++) begin
      lvl = avg_speed[i];
      if ((lvl << 16) < thr) begin
        cnt = low_run[i];
        if (cnt < lim + 64'd1) low_run[i] = low_run[i] + 1'b1;
      end else begin
        low_run[i] = '0;
        faulted[i] = 1'b0;
      end
      cnt = low_run[i];
      if (cnt >= lim) faulted[i] = 1'b1;
    end
    // slowest healthy motor, or the command when every motor is out
    sync = cmd;
    for (int i = 0; i < MAX_MOTORS; i++) begin
      lvl = avg_speed[i];
      if (!faulted[i] && (!any || lvl < sync)) begin
        sync = lvl;
        any  = 1'b1;
      end
    end
    held_sync  = sync[SMOOTH_W-1:0];
    r.status   = STAT_OK;
    r.sync     = sync[SMOOTH_W-1:0];
    r.setpoint = (cmd < sync) ? cmd[SMOOTH_W-1:0] : sync[SMOOTH_W-1:0];
    r.mask     = faulted;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      gain  = GAIN_RST;
      frac  = FRAC_RST;
      ticks = TICKS_RST;
      clear_motors();
      results_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_GAIN:  gain  = cfg_data;
          REG_FRAC:  frac  = cfg_data;
          REG_TICKS: ticks = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) results_due.push_back(next_sync_result(in_tuser, in_tdata));
      if (out_tvalid && out_tready) begin
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result beat with nothing outstanding, status %0d data %h",
                     $time, out_tuser, out_tdata);
        end else begin
          want = results_due.pop_front();
          if (out_tuser !== want.status || out_tdata[14:0] !== want.sync ||
              out_tdata[29:15] !== want.setpoint || out_tdata[33:30] !== want.mask) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"%0t: mismatch, expected status %0d sync %0d setpoint %0d mask %h,",
                        " got status %0d sync %0d setpoint %0d mask %h"},
                       $time, want.status, want.sync, want.setpoint, want.mask,
                       out_tuser, out_tdata[14:0], out_tdata[29:15], out_tdata[33:30]);
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= results_due.size();
  end

endmodule

@@ dv/testbench.sv @@
// stimulus and verdict for the multi-motor speed sync unit
`timescale 1ns / 1ps

module testbench;

  import mssu_pkg::*;
  import mssu_tb_pkg::*;

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [COEF_W-1:0]      cfg_data;
  int                     fail_count;
  int                     pending;

  // no idling on either side while set
  bit steady = 1'b0;

  // current run of well-formed updates: commanded speed and per-motor behavior
  int run_cmd;
  int motor_mode [MAX_MOTORS];

  multi_motor_speed_sync_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mssu_checker sync_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop in case a handshake never completes
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side: random stall before each beat, then hold ready until one lands
  initial begin
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  function automatic logic [IN_TDATA_W-1:0] speed_beat(
      input logic [SPEED_W-1:0] s0, s1, s2, s3, cmd, step);
    return {step, cmd, s3, s2, s1, s0};
  endfunction

  // one input beat, after a random gap; valid stays up across back-to-back beats
  task automatic send_beat(input logic kind, input logic [IN_TDATA_W-1:0] data);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_update(input logic [SPEED_W-1:0] s0, s1, s2, s3, cmd, step);
    send_beat(REQ_UPDATE, speed_beat(s0, s1, s2, s3, cmd, step));
  endtask

  // hold off until every outstanding result beat has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // registers only change with the pipeline empty; the unused index goes along too
  task automatic load_coefs(input logic [COEF_W-1:0] g, f, t);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [COEF_W-1:0]    val [4];
    idx = '{REG_GAIN, REG_FRAC, REG_TICKS, REG_UNUSED};
    val = '{g, f, t, COEF_W'($urandom)};
    drain();
    for (int k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  // pick a fresh commanded speed and a behavior for every motor
  task automatic new_run();
    case ($urandom_range(0, 5))
      0:       run_cmd = 0;
      1:       run_cmd = 32767;
      default: run_cmd = $urandom_range(256, 32767);
    endcase
    for (int i = 0; i < MAX_MOTORS; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: motor_mode[i] = 0;   // tracks the command
        5, 6, 7:       motor_mode[i] = 1;   // lags well below it
        8:             motor_mode[i] = 2;   // reads negative
        default:       motor_mode[i] = 3;   // anywhere in range
      endcase
    end
    steady = ($urandom_range(0, 3) == 0);
  endtask

  // mostly well-formed updates of the current run, plus clears, bad args and noise
  task automatic send_random();
    logic [SPEED_W-1:0] spd [MAX_MOTORS];
    int pick, lo, hi;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      send_beat(REQ_CLEAR, {$urandom, $urandom, $urandom});
    end else if (pick < 8) begin
      send_update(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'h8000 | 16'($urandom), 16'($urandom));
    end else if (pick < 11) begin
      send_update(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'd0);
    end else if (pick < 17) begin
      send_beat(REQ_UPDATE, {$urandom, $urandom, $urandom});
    end else begin
      for (int i = 0; i < MAX_MOTORS; i++) begin
        case (motor_mode[i])
          0: begin
            lo = run_cmd - run_cmd / 8;
            hi = run_cmd + run_cmd / 8;
            if (hi > 32767) hi = 32767;
            spd[i] = 16'($urandom_range(lo, hi));
          end
          1:       spd[i] = 16'($urandom_range(0, run_cmd / 4));
          2:       spd[i] = 16'h8000 | 16'($urandom);
          default: spd[i] = 16'($urandom_range(0, 32767));
        endcase
      end
      send_update(spd[0], spd[1], spd[2], spd[3], 16'(run_cmd),
                  16'($urandom_range(1, 65535)));
    end
  endtask

  initial begin
    logic [COEF_W-1:0] gains [6];
    logic [COEF_W-1:0] fracs [6];
    logic [COEF_W-1:0] tick_lims [6];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tuser   = REQ_UPDATE;
    in_tdata   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_GAIN;
    cfg_data   = '0;
    // extremes of each register, zeros included, then a random setting
    gains     = '{16'd65535, 16'd1, 16'd0, 16'd40000, 16'd65535, 16'($urandom)};
    fracs     = '{16'd65535, 16'd1, 16'd0, 16'd32768, 16'd50000, 16'($urandom)};
    tick_lims = '{16'd1, 16'd65535, 16'd0, 16'd3, 16'd0, 16'($urandom_range(0, 20))};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at reset settings
    send_beat(REQ_CLEAR, {$urandom, $urandom, $urandom});
    send_update(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'hffff);
    // negative speeds clamp to zero, zero command never counts as low
    send_update(16'h8000, 16'h8000, 16'hffff, 16'h8000, 16'h0000, 16'h0001);
    send_update(16'h0000, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 16'h0001);
    // invalid: negative command, zero step time, both
    send_update(16'h1234, 16'h0100, 16'h7fff, 16'h0000, 16'hffff, 16'h0010);
    send_update(16'h1234, 16'h0100, 16'h7fff, 16'h0000, 16'h0400, 16'h0000);
    send_update(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h0000);
    // every motor stalls: faults at the tick limit, sync falls back to command,
    // counters saturate past it
    repeat (12) send_update(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h0001);
    // recovery climbs back
    repeat (4) send_update(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0002);
    send_beat(REQ_CLEAR, '0);

    // random part, one register setting per phase
    for (int p = 0; p < 6; p++) begin
      load_coefs(gains[p], fracs[p], tick_lims[p]);
      for (int n = 0; n < 92; n++) begin
        if (n % 30 == 0) new_run();
        // sender holds off once mid-phase until the pipeline runs dry
        if (n == 46) drain();
        send_random();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
